[src/wma_pkg.sv]
`default_nettype none

package wma_pkg;

  // default sizes
  localparam int MAX_TAPS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int AVG_BITS  = 16;
  localparam int HELD_BITS = 6;
  localparam int WIN_BITS  = 6;

  // window length after reset, before saturation
  localparam int WIN_RESET = 32;

  // input command codes
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[src/wma_ram.sv]
`default_nettype none

module wma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire                                       clk,
  input  wire                                       wr_en,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]                          wr_data,
  input  wire                                       rd_en,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/windowed_moving_average.sv]
// Sequence: a sample is read from the ring on acceptance, updated in ST_UPDATE, divided
//   in ST_DIV and loaded out of ST_DONE; a clear goes from ST_IDLE straight to ST_DONE.
// Throughput: one transaction at a time; the serial restoring divider, one
//   quotient bit per cycle, sets the rate. A new input is taken while a result waits.
// Reset: synchronous, active low; window set to 32 (saturated to MAX_TAPS), ring,
//   sum, position and fill count cleared through per-entry valid bits, no sweep.
`default_nettype none

module windowed_moving_average
  import wma_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    in_command,
  input  wire  [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [AVG_BITS-1:0]    out_average,
  output logic [HELD_BITS-1:0]   out_samples_held,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [WIN_BITS-1:0]    cfg_window_len
);

  localparam int AW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_BITS  = $clog2(MAX_TAPS + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_TAPS);
  localparam int STEP_BITS = $clog2(SUM_BITS);
  localparam int WIN_INIT  = (WIN_RESET > MAX_TAPS) ? MAX_TAPS : WIN_RESET;

  state_t state_r, state_nxt;

  logic [CNT_BITS-1:0]        win_r, win_nxt;
  logic [CNT_BITS-1:0]        fill_r, fill_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [MAX_TAPS-1:0]        vld_r, vld_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [SUM_BITS-1:0]           dq_r, dq_nxt;
  logic [CNT_BITS-1:0]           rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic [STEP_BITS-1:0]          step_r, step_nxt;
  logic [AVG_BITS-1:0]           avg_r;
  logic [HELD_BITS-1:0]          held_r;

  logic                       in_acc, cfg_acc, out_free, out_load;
  logic                       ram_rd_en, ram_wr_en;
  logic [SAMPLE_BITS-1:0]     ram_rd_data;
  logic signed [SUM_BITS-1:0] old_ext, new_sum, quo;
  logic [CNT_BITS:0]          rem_sh, rem_sub;
  logic                       q_bit;
  logic [CNT_BITS-1:0]        pos_inc;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || !out_stall;

  // sample ring
  wma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (pos_r),
    .wr_data (sample_r),
    .rd_en   (ram_rd_en),
    .rd_addr (pos_r),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_command == CMD_CLEAR) ? ST_DONE : ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = (state_r == ST_IDLE);
    ram_rd_en = in_acc;
    ram_wr_en = (state_r == ST_UPDATE);
    out_load  = (state_r == ST_DONE) && out_free;
  end

  // read-modify-write of the oldest entry and divider step
  always_comb begin
    old_ext = vld_r[pos_r] ? SUM_BITS'($signed(ram_rd_data)) : '0;
    new_sum = sum_r - old_ext + SUM_BITS'(sample_r);
    pos_inc = CNT_BITS'(pos_r) + CNT_BITS'(1);

    rem_sh  = {rem_r, dq_r[SUM_BITS-1]};
    rem_sub = rem_sh - {1'b0, fill_r};
    q_bit   = (rem_sh >= {1'b0, fill_r});

    quo = neg_r ? -$signed(dq_r) : $signed(dq_r);

    win_nxt       = win_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_acc) begin
      // window write saturates and clears the filter
      if (cfg_window_len == '0) begin
        win_nxt = CNT_BITS'(1);
      end else if (int'(cfg_window_len) > MAX_TAPS) begin
        win_nxt = CNT_BITS'(MAX_TAPS);
      end else begin
        win_nxt = CNT_BITS'(cfg_window_len);
      end
    end

    // window write or clear transaction empties the filter
    if (cfg_acc || (in_acc && in_command == CMD_CLEAR)) begin
      fill_nxt = '0;
      pos_nxt  = '0;
      sum_nxt  = '0;
      vld_nxt  = '0;
      dq_nxt   = '0;
      neg_nxt  = 1'b0;
    end

    case (state_r)
      ST_UPDATE: begin
        sum_nxt        = new_sum;
        vld_nxt[pos_r] = 1'b1;
        pos_nxt        = (pos_inc == win_r) ? '0 : AW'(pos_inc);
        if (fill_r < win_r) begin
          fill_nxt = fill_r + CNT_BITS'(1);
        end
        // divider setup on the magnitude of the new sum
        neg_nxt  = new_sum[SUM_BITS-1];
        dq_nxt   = new_sum[SUM_BITS-1] ? -new_sum : new_sum;
        rem_nxt  = '0;
        step_nxt = STEP_BITS'(SUM_BITS - 1);
      end
      ST_DIV: begin
        rem_nxt  = q_bit ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
        dq_nxt   = {dq_r[SUM_BITS-2:0], q_bit};
        step_nxt = step_r - STEP_BITS'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= CNT_BITS'(WIN_INIT);
      fill_r      <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
    end
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    if (out_load) begin
      avg_r  <= AVG_BITS'(quo);
      held_r <= HELD_BITS'(fill_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average      = avg_r;
  assign out_samples_held = held_r;

`ifndef ASSERT_OFF
  // fill count never exceeds the window
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r)
    else $error("fill count above window length");

  // write position stays inside the window
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_BITS'(pos_r) < win_r)
    else $error("write position outside window");

  // a clear transaction empties the window
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_command == CMD_CLEAR |=> fill_r == '0 && state_r == ST_DONE)
    else $error("clear did not empty the filter");

  // divider keeps iterating until its step count runs out
  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && step_r != '0 |=> state_r == ST_DIV)
    else $error("divider left early");

  // a sample always leaves at least one entry held
  a_sample_fills: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPDATE |=> fill_r != '0)
    else $error("sample update left window empty");
`endif

endmodule

`default_nettype wire

[bench/windowed_moving_average_check.sv]
`default_nettype none

module windowed_moving_average_check
  import wma_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  input  wire                       in_stall,
  input  wire                       in_command,
  input  wire  [SAMPLE_BITS_DEF-1:0] in_sample,
  input  wire                       out_valid,
  input  wire                       out_stall,
  input  wire  [AVG_BITS-1:0]       out_average,
  input  wire  [HELD_BITS-1:0]      out_samples_held,
  input  wire                       cfg_valid,
  input  wire                       cfg_ready,
  input  wire  [WIN_BITS-1:0]       cfg_window_len,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic signed [AVG_BITS-1:0] average;
    logic [HELD_BITS-1:0]       held;
  } avg_result_t;

  // mirror of the filter state
  int          taps [MAX_TAPS_DEF];
  int          tap_pos;
  int          tap_sum;
  int          tap_fill;
  int          window;
  int          mismatches = 0;
  avg_result_t avg_queue [$];

  // empty ring, zero sum, position and fill
  function automatic void clear_window();
    foreach (taps[i]) taps[i] = 0;
    tap_pos  = 0;
    tap_sum  = 0;
    tap_fill = 0;
  endfunction

  // written length is forced into 1..MAX_TAPS
  function automatic int saturate_window(logic [WIN_BITS-1:0] len);
    if (len == '0) return 1;
    if (len > MAX_TAPS_DEF) return MAX_TAPS_DEF;
    return int'(len);
  endfunction

  // replace the oldest tap and average what the window holds
  function automatic avg_result_t add_sample(logic signed [SAMPLE_BITS_DEF-1:0] x);
    avg_result_t r;
    int          quot;
    if (tap_pos >= window) tap_pos = 0;
    tap_sum       = tap_sum - taps[tap_pos] + int'(x);
    taps[tap_pos] = int'(x);
    tap_pos       = (tap_pos + 1) % window;
    if (tap_fill < window) tap_fill++;
    quot      = tap_sum / tap_fill;
    r.average = quot[AVG_BITS-1:0];
    r.held    = tap_fill[HELD_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    avg_result_t want;
    if (!rst_n) begin
      window = saturate_window(WIN_BITS'(WIN_RESET));
      clear_window();
      avg_queue.delete();
    end else begin
      // window write also clears the filter
      if (cfg_valid && cfg_ready) begin
        window = saturate_window(cfg_window_len);
        clear_window();
      end
      // input transaction
      if (in_valid && !in_stall) begin
        if (cmd_t'(in_command) == CMD_CLEAR) begin
          clear_window();
          avg_queue.push_back('0);
        end else begin
          avg_queue.push_back(add_sample(in_sample));
        end
      end
      // result transaction against the oldest expectation
      if (out_valid && !out_stall) begin
        if (avg_queue.size() == 0) begin
          $error("result transaction with nothing expected: average %0d samples_held %0d",
                 $signed(out_average), out_samples_held);
          mismatches++;
        end else begin
          want = avg_queue.pop_front();
          if (out_average !== want.average) begin
            $error("average: expected %0d, got %0d", $signed(want.average),
                   $signed(out_average));
            mismatches++;
          end
          if (out_samples_held !== want.held) begin
            $error("samples_held: expected %0d, got %0d", want.held, out_samples_held);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= avg_queue.size();
  end

endmodule

`default_nettype wire

[bench/windowed_moving_average_test.sv]
`default_nettype none

module windowed_moving_average_test;
  import wma_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 38;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  wire                        in_stall;
  cmd_t                       in_command     = CMD_SAMPLE;
  logic [SAMPLE_BITS_DEF-1:0] in_sample      = '0;
  wire                        out_valid;
  logic                       out_stall      = 1'b0;
  wire  [AVG_BITS-1:0]        out_average;
  wire  [HELD_BITS-1:0]       out_samples_held;
  logic                       cfg_valid      = 1'b0;
  wire                        cfg_ready;
  logic [WIN_BITS-1:0]        cfg_window_len = '0;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;

  // window lengths per phase, zero and above-range ones included
  logic [WIN_BITS-1:0] win_list [PHASES] = '{6'd1, 6'd2, 6'd3, 6'd32, 6'd5, 6'd0,
                                             6'd8, 6'd31, 6'd63, 6'd2, 6'd16, 6'd33};

  windowed_moving_average u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_average      (out_average),
    .out_samples_held (out_samples_held),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_len   (cfg_window_len)
  );

  windowed_moving_average_check u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_average      (out_average),
    .out_samples_held (out_samples_held),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_len   (cfg_window_len),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("windowed_moving_average: mismatch");
      $finish;
    end
  end

  // random backpressure on results
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // one input transaction, with a random gap ahead of it
  task automatic send_item(cmd_t cmd, logic [SAMPLE_BITS_DEF-1:0] smp);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_sample  <= smp;
    do @(posedge clk); while (in_stall);
  endtask

  // window write once every result is back
  task automatic write_window(logic [WIN_BITS-1:0] len);
    do @(posedge clk); while (pending != 0);
    cfg_valid      <= 1'b1;
    cfg_window_len <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [WIN_BITS-1:0]        win;
    logic [SAMPLE_BITS_DEF-1:0] smp;
    cmd_t                       cmd;
    int                         clear_pct;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default window: clear when empty, extremes, truncation of negative sums
    send_item(CMD_CLEAR, 16'h1234);
    send_item(CMD_SAMPLE, 16'h8000);
    send_item(CMD_SAMPLE, 16'h7fff);
    send_item(CMD_SAMPLE, 16'hffff);
    send_item(CMD_SAMPLE, 16'h8000);
    send_item(CMD_SAMPLE, 16'h8000);
    send_item(CMD_SAMPLE, 16'h0001);
    send_item(CMD_CLEAR, 16'hffff);
    send_item(CMD_SAMPLE, 16'hfffd);
    send_item(CMD_SAMPLE, 16'h0000);
    in_valid <= 1'b0;

    // zero length saturates to a single tap
    write_window(6'd0);
    send_item(CMD_SAMPLE, 16'h8000);
    send_item(CMD_SAMPLE, 16'h7fff);
    send_item(CMD_SAMPLE, 16'hfffb);
    send_item(CMD_CLEAR, 16'h0000);
    send_item(CMD_SAMPLE, 16'h0003);
    in_valid <= 1'b0;

    // all ones saturates to the full ring
    write_window(6'd63);
    send_item(CMD_SAMPLE, 16'h7fff);
    send_item(CMD_SAMPLE, 16'h7fff);
    send_item(CMD_SAMPLE, 16'h7fff);
    send_item(CMD_SAMPLE, 16'h8000);
    in_valid <= 1'b0;

    // one past the ring size
    write_window(6'd33);
    send_item(CMD_SAMPLE, 16'h0005);
    send_item(CMD_SAMPLE, 16'hfffe);
    in_valid <= 1'b0;

    // random phases over window lengths and idle patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct  =  (ph % 4 == 1) ? 68 : (ph % 4 == 3) ? 37 : 0;
      stall_pct <= (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 37 : 0;
      win = (ph % 6 == 5) ? WIN_BITS'($urandom_range(0, 63)) : win_list[ph];
      write_window(win);
      // long windows need long runs without a clear to fill up
      clear_pct = (win >= 16) ? 1 : 6;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        cmd = ($urandom_range(0, 99) < clear_pct) ? CMD_CLEAR : CMD_SAMPLE;
        // some phases lean on one rail to push the sum to its limits
        if (ph % 3 != 0 && $urandom_range(0, 1) == 1)
          smp = (ph % 3 == 1) ? 16'h7fff : 16'h8000;
        else
          smp = pick_sample();
        send_item(cmd, smp);
      end
      in_valid <= 1'b0;
    end

    // drain, then verdict
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("windowed_moving_average: match");
    end else begin
      $display("windowed_moving_average: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
src/wma_pkg.sv
src/wma_ram.sv
src/windowed_moving_average.sv
bench/windowed_moving_average_check.sv
bench/windowed_moving_average_test.sv
